@@ hw/rtl/kocc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the key occurrence counter.
package kocc_pkg;

   localparam int ENTRIES     = 64;
   localparam int IDX_W       = $clog2(ENTRIES);
   localparam int FILL_W      = $clog2(ENTRIES + 1);
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int KEY_LOW_W  = 64;
   localparam int KEY_HIGH_W = 56;
   localparam int KEY_W      = KEY_LOW_W + KEY_HIGH_W;
   localparam int COUNT_W    = 16;

   localparam logic [COUNT_W-1:0] COUNT_MAX      = {COUNT_W{1'b1}};
   localparam logic [COUNT_W-1:0] COUNT_ONE      = COUNT_W'(1);
   localparam logic [COUNT_W-1:0] THRESHOLD_RESET = COUNT_W'(4);

   localparam logic ACTION_COUNT  = 1'b0;
   localparam logic ACTION_REPORT = 1'b1;

   typedef logic [KEY_W-1:0] key_type;

   typedef enum logic [2:0] {
      KIND_EXISTING = 3'd0,
      KIND_NEW      = 3'd1,
      KIND_FULL     = 3'd2,
      KIND_REPORT   = 3'd3,
      KIND_EMPTY    = 3'd4
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MATCH,
      ST_READ,
      ST_UPDATE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic                  action;
      logic [KEY_LOW_W-1:0]  key_low;
      logic [KEY_HIGH_W-1:0] key_high;
   } req_type;

   typedef struct packed {
      kind_type              kind;
      logic [KEY_LOW_W-1:0]  entry_key_low;
      logic [KEY_HIGH_W-1:0] entry_key_high;
      logic [COUNT_W-1:0]    entry_count;
      logic                  last;
   } rsp_type;

   // Queue head as seen by the back end.
   typedef struct packed {
      logic    not_empty;
      req_type item;
   } queue_status_type;

   // Key table write port.
   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      key_type          key;
   } cam_write_type;

   // Registered lookup result.
   typedef struct packed {
      logic             hit;
      logic [IDX_W-1:0] idx;
   } cam_match_type;

endpackage

@@ hw/rtl/kocc_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts command words into a short queue for the back end.
module kocc_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   output logic                       busy,
   input  kocc_pkg::req_type          req_item,
   input  logic                       pop,
   output kocc_pkg::queue_status_type status
);

   kocc_pkg::req_type               slot_ff [kocc_pkg::QUEUE_DEPTH];
   logic [kocc_pkg::QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [kocc_pkg::QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [kocc_pkg::QCNT_W-1:0]     count_ff, count_in;
   logic                            push;
   logic                            do_pop;

   assign busy   = (count_ff == kocc_pkg::QCNT_W'(kocc_pkg::QUEUE_DEPTH));
   assign push   = start && !busy;
   assign do_pop = pop && (count_ff != '0);

   assign status.not_empty = (count_ff != '0);
   assign status.item      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == kocc_pkg::QPTR_W'(kocc_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == kocc_pkg::QPTR_W'(kocc_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_item;
      end
   end

endmodule

@@ hw/rtl/kocc_cam.sv @@
`timescale 1ns / 1ps
// Key table held in flops with a parallel compare against all stored keys.
module kocc_cam (
   input  logic                              clock,
   input  kocc_pkg::cam_write_type           wr,
   input  kocc_pkg::key_type                 lookup_key,
   input  logic [kocc_pkg::FILL_W-1:0]       fill,
   output kocc_pkg::cam_match_type           match
);

   kocc_pkg::key_type                  keys_ff [kocc_pkg::ENTRIES];
   logic [kocc_pkg::ENTRIES-1:0]       hit_vec;
   kocc_pkg::cam_match_type            match_ff, match_in;

   always_comb begin
      for (int i = 0; i < kocc_pkg::ENTRIES; i++) begin
         hit_vec[i] = (kocc_pkg::FILL_W'(i) < fill) && (keys_ff[i] == lookup_key);
      end
   end

   // Stored keys are unique, so OR the indexes of the hits together.
   always_comb begin
      match_in = '0;
      for (int i = 0; i < kocc_pkg::ENTRIES; i++) begin
         if (hit_vec[i]) begin
            match_in.hit = 1'b1;
            match_in.idx = match_in.idx | kocc_pkg::IDX_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      match_ff <= match_in;
      if (wr.en) begin
         keys_ff[wr.idx] <= wr.key;
      end
   end

   assign match = match_ff;

endmodule

@@ hw/rtl/kocc_back.sv @@
`timescale 1ns / 1ps
// Back end: sequencer that updates counts, appends keys and walks reports.
module kocc_back (
   input  logic                             clock,
   input  logic                             reset,
   input  kocc_pkg::queue_status_type       status,
   output logic                             pop,
   input  logic                             csr_wr_en,
   input  logic [kocc_pkg::COUNT_W-1:0]     csr_wr_data,
   output logic                             rsp_strobe,
   output kocc_pkg::rsp_type                rsp_item
);

   kocc_pkg::state_type                state_ff, state_in;
   kocc_pkg::req_type                  item_ff, item_in;
   logic [kocc_pkg::FILL_W-1:0]        fill_ff, fill_in;
   logic [kocc_pkg::FILL_W-1:0]        ptr_ff, ptr_in;
   logic                               rd_valid_ff, rd_valid_in;
   logic                               pend_valid_ff, pend_valid_in;
   kocc_pkg::rsp_type                  pend_ff, pend_in;
   logic [kocc_pkg::COUNT_W-1:0]       threshold_ff;
   logic                               rsp_strobe_ff, rsp_strobe_in;
   kocc_pkg::rsp_type                  rsp_ff, rsp_in;

   logic [kocc_pkg::COUNT_W-1:0]       count_mem [kocc_pkg::ENTRIES];
   kocc_pkg::key_type                  key_mem [kocc_pkg::ENTRIES];
   logic [kocc_pkg::COUNT_W-1:0]       count_rd_ff;
   kocc_pkg::key_type                  key_rd_ff;

   logic                               mem_rd_en;
   logic [kocc_pkg::IDX_W-1:0]         mem_rd_addr;
   logic                               cnt_wr_en;
   logic [kocc_pkg::IDX_W-1:0]         cnt_wr_addr;
   logic [kocc_pkg::COUNT_W-1:0]       cnt_wr_data;
   logic                               key_wr_en;
   logic [kocc_pkg::COUNT_W-1:0]       next_count;
   kocc_pkg::key_type                  item_key;
   kocc_pkg::cam_write_type            cam_wr;
   kocc_pkg::cam_match_type            match;

   assign item_key = {item_ff.key_high, item_ff.key_low};

   assign cam_wr.en  = key_wr_en;
   assign cam_wr.idx = fill_ff[kocc_pkg::IDX_W-1:0];
   assign cam_wr.key = item_key;

   kocc_cam u_cam (
      .clock      (clock),
      .wr         (cam_wr),
      .lookup_key (item_key),
      .fill       (fill_ff),
      .match      (match)
   );

   assign next_count = (count_rd_ff == kocc_pkg::COUNT_MAX) ?
                       count_rd_ff : count_rd_ff + 1'b1;

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      fill_in       = fill_ff;
      ptr_in        = ptr_ff;
      rd_valid_in   = rd_valid_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      pop           = 1'b0;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = ptr_ff[kocc_pkg::IDX_W-1:0];
      cnt_wr_en     = 1'b0;
      cnt_wr_addr   = match.idx;
      cnt_wr_data   = next_count;
      key_wr_en     = 1'b0;

      case (state_ff)
         kocc_pkg::ST_IDLE: begin
            if (status.not_empty) begin
               pop     = 1'b1;
               item_in = status.item;
               if (status.item.action == kocc_pkg::ACTION_REPORT) begin
                  ptr_in        = '0;
                  rd_valid_in   = 1'b0;
                  pend_valid_in = 1'b0;
                  state_in      = kocc_pkg::ST_SCAN;
               end else begin
                  state_in = kocc_pkg::ST_MATCH;
               end
            end
         end

         kocc_pkg::ST_MATCH: begin
            state_in = kocc_pkg::ST_READ;
         end

         kocc_pkg::ST_READ: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = match.idx;
            state_in    = kocc_pkg::ST_UPDATE;
         end

         kocc_pkg::ST_UPDATE: begin
            rsp_strobe_in         = 1'b1;
            rsp_in.entry_key_low  = item_ff.key_low;
            rsp_in.entry_key_high = item_ff.key_high;
            rsp_in.last           = 1'b1;
            if (match.hit) begin
               cnt_wr_en          = 1'b1;
               rsp_in.kind        = kocc_pkg::KIND_EXISTING;
               rsp_in.entry_count = next_count;
            end else if (fill_ff < kocc_pkg::FILL_W'(kocc_pkg::ENTRIES)) begin
               cnt_wr_en          = 1'b1;
               cnt_wr_addr        = fill_ff[kocc_pkg::IDX_W-1:0];
               cnt_wr_data        = kocc_pkg::COUNT_ONE;
               key_wr_en          = 1'b1;
               fill_in            = fill_ff + 1'b1;
               rsp_in.kind        = kocc_pkg::KIND_NEW;
               rsp_in.entry_count = kocc_pkg::COUNT_ONE;
            end else begin
               rsp_in.kind        = kocc_pkg::KIND_FULL;
               rsp_in.entry_count = '0;
            end
            state_in = kocc_pkg::ST_IDLE;
         end

         kocc_pkg::ST_SCAN: begin
            if (ptr_ff < fill_ff) begin
               mem_rd_en   = 1'b1;
               ptr_in      = ptr_ff + 1'b1;
               rd_valid_in = 1'b1;
            end else begin
               rd_valid_in = 1'b0;
            end
            // Hold one qualifying entry back so the final one can carry last.
            if (rd_valid_ff && (count_rd_ff > threshold_ff)) begin
               if (pend_valid_ff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_in        = pend_ff;
               end
               pend_valid_in          = 1'b1;
               pend_in.kind           = kocc_pkg::KIND_REPORT;
               pend_in.entry_key_low  = key_rd_ff[kocc_pkg::KEY_LOW_W-1:0];
               pend_in.entry_key_high = key_rd_ff[kocc_pkg::KEY_W-1:kocc_pkg::KEY_LOW_W];
               pend_in.entry_count    = count_rd_ff;
               pend_in.last           = 1'b0;
            end
            if ((ptr_ff == fill_ff) && !rd_valid_ff) begin
               state_in = kocc_pkg::ST_FINISH;
            end
         end

         kocc_pkg::ST_FINISH: begin
            rsp_strobe_in = 1'b1;
            if (pend_valid_ff) begin
               rsp_in      = pend_ff;
               rsp_in.last = 1'b1;
            end else begin
               rsp_in.kind           = kocc_pkg::KIND_EMPTY;
               rsp_in.entry_key_low  = '0;
               rsp_in.entry_key_high = '0;
               rsp_in.entry_count    = '0;
               rsp_in.last           = 1'b1;
            end
            state_in = kocc_pkg::ST_IDLE;
         end

         default: begin
            state_in = kocc_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= kocc_pkg::ST_IDLE;
         fill_ff       <= '0;
         ptr_ff        <= '0;
         rd_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         threshold_ff  <= kocc_pkg::THRESHOLD_RESET;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         ptr_ff        <= ptr_in;
         rd_valid_ff   <= rd_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_wr_en) begin
            threshold_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (cnt_wr_en) begin
         count_mem[cnt_wr_addr] <= cnt_wr_data;
      end
      if (key_wr_en) begin
         key_mem[fill_ff[kocc_pkg::IDX_W-1:0]] <= item_key;
      end
      if (mem_rd_en) begin
         count_rd_ff <= count_mem[mem_rd_addr];
         key_rd_ff   <= key_mem[mem_rd_addr];
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

@@ hw/rtl/key_occurrence_counter_core.sv @@
`timescale 1ns / 1ps
// Count item: once the back end pops the word, it runs the match, read and update states and
// registers the result strobe; no new word is popped before it is done. Report item: one stored
// entry is read per cycle up to the final word (an empty word if no entry qualifies); results
// leave at most one per cycle, in insertion order; a 2-word queue lets start lead the back end.
// Reset clears the queue, the fill level and sets the threshold to 4; the tables are not cleared.
// Results are strobed for one cycle and cannot be stalled by the receiver.
module key_occurrence_counter_core (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  kocc_pkg::req_type              req_item,
   output logic                           rsp_strobe,
   output kocc_pkg::rsp_type              rsp_item,
   input  logic                           csr_wr_en,
   input  logic [kocc_pkg::COUNT_W-1:0]   csr_wr_data
);

   kocc_pkg::queue_status_type status;
   logic                       pop;

   kocc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .pop      (pop),
      .status   (status)
   );

   kocc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .status      (status),
      .pop         (pop),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_strobe  (rsp_strobe),
      .rsp_item    (rsp_item)
   );

endmodule
